### hdl/fir_mac_pkg.sv
`timescale 1ns / 1ps

package fir_mac_pkg;

  localparam int CMD_W      = 2;
  localparam int COEF_IDX_W = 6;
  localparam int TAP_CNT_W  = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_COEF  = 2'd0,
    CMD_CLEAR_HIST = 2'd1,
    CMD_FILTER     = 2'd2
  } fir_cmd_t;

  // Control from the sequencer to the multiply-accumulate datapath.
  typedef struct packed {
    logic acc_clr;
    logic rd_vld;
    logic hist_zero;
    logic rnd_en;
  } fir_mac_ctl_t;

endpackage

### hdl/fir_mac_if.sv
`timescale 1ns / 1ps

interface fir_mac_in_if #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int COEF_WIDTH   = 18
);
  import fir_mac_pkg::*;

  logic                           valid;
  logic                           ready;
  logic [CMD_W-1:0]               cmd;
  logic [COEF_IDX_W-1:0]          coef_index;
  logic signed [COEF_WIDTH-1:0]   coef_value;
  logic signed [SAMPLE_WIDTH-1:0] sample_in;
  logic                           last_in;

  modport source (
    output valid, cmd, coef_index, coef_value, sample_in, last_in,
    input  ready
  );

  modport sink (
    input  valid, cmd, coef_index, coef_value, sample_in, last_in,
    output ready
  );
endinterface

interface fir_mac_out_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_out;
  logic                           last_out;
  logic                           saturated;

  modport source (
    output valid, sample_out, last_out, saturated,
    input  ready
  );

  modport sink (
    input  valid, sample_out, last_out, saturated,
    output ready
  );
endinterface

### hdl/fir_mac_dp.sv
`timescale 1ns / 1ps

module fir_mac_dp #(
  parameter int MAX_TAPS     = 64,
  parameter int SAMPLE_WIDTH = 16,
  parameter int COEF_WIDTH   = 18
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  fir_mac_pkg::fir_mac_ctl_t      ctl,
  input  logic signed [COEF_WIDTH-1:0]   coef_q,
  input  logic signed [SAMPLE_WIDTH-1:0] hist_q,
  output logic                           mac_busy,
  output logic signed [SAMPLE_WIDTH-1:0] res_sample,
  output logic                           res_sat
);
  import fir_mac_pkg::*;

  localparam int PW      = SAMPLE_WIDTH + COEF_WIDTH;
  localparam int ACC_NAT = PW + $clog2(MAX_TAPS);
  localparam int ACC_W   = (ACC_NAT > 64) ? 64 : ACC_NAT;
  localparam int SH      = COEF_WIDTH - 2;

  localparam logic signed [ACC_W-1:0] HALF   = ACC_W'(1) << (SH - 1);
  localparam logic signed [ACC_W-1:0] SAT_HI =
    $signed({{(ACC_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}});
  localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

  logic                           pv_r;
  logic signed [PW-1:0]           prod_r;
  logic signed [ACC_W-1:0]        acc_r;
  logic signed [ACC_W-1:0]        sum_r;
  logic signed [SAMPLE_WIDTH-1:0] h_op;
  logic signed [ACC_W-1:0]        shifted;

  assign h_op     = ctl.hist_zero ? '0 : hist_q;
  assign mac_busy = pv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else begin
      pv_r <= ctl.rd_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_vld) begin
      prod_r <= coef_q * h_op;
    end
    if (ctl.acc_clr) begin
      acc_r <= '0;
    end else if (pv_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
    if (ctl.rnd_en) begin
      sum_r <= acc_r + HALF;
    end
  end

  // Round half up was folded into sum_r; the shift drops the extra fraction bits.
  always_comb begin
    shifted = sum_r >>> SH;
    if (shifted > SAT_HI) begin
      res_sample = SAMPLE_WIDTH'(SAT_HI);
      res_sat    = 1'b1;
    end else if (shifted < SAT_LO) begin
      res_sample = SAMPLE_WIDTH'(SAT_LO);
      res_sat    = 1'b1;
    end else begin
      res_sample = shifted[SAMPLE_WIDTH-1:0];
      res_sat    = 1'b0;
    end
  end

  a_clr_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.acc_clr |-> !pv_r && !ctl.rd_vld)
    else $error("accumulator cleared while products are in flight");

  a_rnd_drained: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.rnd_en |-> !pv_r && !ctl.rd_vld)
    else $error("rounding started before the last product was added");

  a_prod_follows: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.rd_vld |=> pv_r)
    else $error("product stage lost a read");

endmodule

### hdl/fir_filter_mac.sv
`timescale 1ns / 1ps

// Channel   Direction  Payload
// in_chan   sink       cmd, coef_index, coef_value, sample_in, last_in
// out_chan  source     sample_out, last_out, saturated
// cfg_*     write      tap_count (write enable and data, no read-back)
//
// A coefficient load or a history clear completes on its transfer. A filter command
// steps through min(tap_count, MAX_TAPS) taps, one tap per cycle through the single
// multiply-accumulate, fed by one read of each memory per cycle, then drains the
// pipeline; with no tap in use it goes straight to the drain.
// After reset a clearing pass zeroes the coefficient memory; no input transfer is
// taken during it. The history is tracked by a fill count.
// The next item is taken while a result waits in the output register; a filter
// command then stalls only at its final step until out_chan takes the result.

module fir_filter_mac #(
  parameter int MAX_TAPS     = 64,
  parameter int SAMPLE_WIDTH = 16,
  parameter int COEF_WIDTH   = 18
) (
  input  logic                                clk,
  input  logic                                rst_n,
  fir_mac_in_if.sink                          in_chan,
  fir_mac_out_if.source                       out_chan,
  input  logic                                cfg_wr_en,
  input  logic [fir_mac_pkg::TAP_CNT_W-1:0]   cfg_wr_data
);
  import fir_mac_pkg::*;

  localparam int AW  = $clog2(MAX_TAPS);
  localparam int TCW = $clog2(MAX_TAPS + 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MAC,
    S_DRAIN,
    S_EMIT
  } state_t;

  state_t                         state_r;
  logic [TAP_CNT_W-1:0]           tap_count_r;
  logic [TCW-1:0]                 taps_r;
  logic [TCW-1:0]                 iss_r;
  logic [TCW-1:0]                 fill_r;
  logic [AW-1:0]                  head_r;
  logic [AW-1:0]                  hptr_r;
  logic [AW-1:0]                  clr_addr_r;
  logic signed [SAMPLE_WIDTH-1:0] sample_r;
  logic                           last_r;
  logic                           v1_r;
  logic                           z1_r;
  logic                           out_valid_r;
  logic signed [SAMPLE_WIDTH-1:0] out_sample_r;
  logic                           out_last_r;
  logic                           out_sat_r;

  logic signed [COEF_WIDTH-1:0]   coef_mem [MAX_TAPS];
  logic signed [SAMPLE_WIDTH-1:0] hist_mem [MAX_TAPS];
  logic signed [COEF_WIDTH-1:0]   coef_q_r;
  logic signed [SAMPLE_WIDTH-1:0] hist_q_r;

  logic                           in_fire;
  logic                           idx_ok;
  logic                           coef_we;
  logic [AW-1:0]                  coef_waddr;
  logic signed [COEF_WIDTH-1:0]   coef_wdata;
  logic [TCW-1:0]                 eff_taps;
  logic [AW-1:0]                  head_nxt;
  logic [AW-1:0]                  hptr_nxt;
  logic                           out_free;
  logic                           emit;
  fir_mac_ctl_t                   ctl;
  logic                           mac_busy;
  logic signed [SAMPLE_WIDTH-1:0] res_sample;
  logic                           res_sat;

  assign in_chan.ready       = (state_r == S_IDLE);
  assign in_fire             = in_chan.valid && in_chan.ready;
  assign out_chan.valid      = out_valid_r;
  assign out_chan.sample_out = out_sample_r;
  assign out_chan.last_out   = out_last_r;
  assign out_chan.saturated  = out_sat_r;

  assign idx_ok   = 32'(in_chan.coef_index) < 32'(MAX_TAPS);
  assign eff_taps = (32'(tap_count_r) > 32'(MAX_TAPS)) ? TCW'(MAX_TAPS) : TCW'(tap_count_r);
  assign head_nxt = (head_r == '0) ? AW'(MAX_TAPS - 1) : head_r - 1'b1;
  assign hptr_nxt = (hptr_r == AW'(MAX_TAPS - 1)) ? '0 : hptr_r + 1'b1;
  assign out_free = !out_valid_r || out_chan.ready;
  assign emit     = (state_r == S_EMIT) && out_free;

  always_comb begin
    if (state_r == S_CLEAR) begin
      coef_we    = 1'b1;
      coef_waddr = clr_addr_r;
      coef_wdata = '0;
    end else begin
      coef_we    = in_fire && (in_chan.cmd == CMD_LOAD_COEF) && idx_ok;
      coef_waddr = AW'(in_chan.coef_index);
      coef_wdata = in_chan.coef_value;
    end
  end

  assign ctl.acc_clr   = in_fire && (in_chan.cmd == CMD_FILTER);
  assign ctl.rd_vld    = v1_r;
  assign ctl.hist_zero = z1_r;
  assign ctl.rnd_en    = (state_r == S_DRAIN) && !v1_r && !mac_busy;

  // Coefficient memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (coef_we) begin
      coef_mem[coef_waddr] <= coef_wdata;
    end
    coef_q_r <= coef_mem[iss_r[AW-1:0]];
  end

  // History is a circular buffer; the newest sample sits at head_r.
  always_ff @(posedge clk) begin
    if (emit) begin
      hist_mem[head_nxt] <= sample_r;
    end
    hist_q_r <= hist_mem[hptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      tap_count_r <= TAP_CNT_W'(1);
      fill_r      <= '0;
      head_r      <= '0;
      v1_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        tap_count_r <= cfg_wr_data;
      end
      v1_r <= (state_r == S_MAC);
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_addr_r <= clr_addr_r + 1'b1;
          if (clr_addr_r == AW'(MAX_TAPS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            unique case (in_chan.cmd)
              CMD_CLEAR_HIST: begin
                fill_r <= '0;
              end
              CMD_FILTER: begin
                sample_r <= in_chan.sample_in;
                last_r   <= in_chan.last_in;
                taps_r   <= eff_taps;
                iss_r    <= '0;
                hptr_r   <= head_r;
                state_r  <= (eff_taps == '0) ? S_DRAIN : S_MAC;
              end
              default: begin
              end
            endcase
          end
        end
        S_MAC: begin
          // Entries past the fill count are not cleared in memory; they are read as zero.
          z1_r   <= (iss_r >= fill_r);
          iss_r  <= iss_r + 1'b1;
          hptr_r <= hptr_nxt;
          if (iss_r == taps_r - 1'b1) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!v1_r && !mac_busy) begin
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_sample_r <= res_sample;
            out_last_r   <= last_r;
            out_sat_r    <= res_sat;
            head_r       <= head_nxt;
            if (fill_r != TCW'(MAX_TAPS)) begin
              fill_r <= fill_r + 1'b1;
            end
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  fir_mac_dp #(
    .MAX_TAPS     (MAX_TAPS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COEF_WIDTH   (COEF_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .coef_q     (coef_q_r),
    .hist_q     (hist_q_r),
    .mac_busy   (mac_busy),
    .res_sample (res_sample),
    .res_sat    (res_sat)
  );

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= TCW'(MAX_TAPS))
    else $error("history fill count past the buffer depth");

  a_iss_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MAC) |-> (iss_r < taps_r))
    else $error("tap counter ran past the tap count");

  a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EMIT))
    else $error("result presented outside the final step");

  a_coef_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    coef_we |-> !v1_r && !mac_busy && (state_r != S_MAC))
    else $error("coefficient written while a sum is being formed");

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import fir_mac_pkg::*;

  localparam int MAX_TAPS       = 64;
  localparam int SAMPLE_W       = 16;
  localparam int COEF_W         = 18;
  localparam int PROD_SHIFT     = COEF_W - 2;
  localparam int SETTLE_CYCLES  = MAX_TAPS + 16;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RAND_PHASES    = 20;
  localparam int PHASE_ITEMS    = 46;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam logic signed [SAMPLE_W-1:0] S_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] S_MIN = 16'sh8000;
  localparam logic signed [COEF_W-1:0]   C_MAX = 18'sh1FFFF;
  localparam logic signed [COEF_W-1:0]   C_MIN = 18'sh20000;
  localparam logic signed [COEF_W-1:0]   C_NEG1 = 18'sh3FFFF;

  typedef struct {
    logic [CMD_W-1:0]           cmd;
    logic [COEF_IDX_W-1:0]      idx;
    logic signed [COEF_W-1:0]   coef;
    logic signed [SAMPLE_W-1:0] smp;
    logic                       last;
  } fir_item_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] smp;
    logic                       last;
    logic                       sat;
  } fir_result_t;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [TAP_CNT_W-1:0] cfg_wr_data;

  fir_mac_in_if #(.SAMPLE_WIDTH(SAMPLE_W), .COEF_WIDTH(COEF_W)) in_chan ();
  fir_mac_out_if #(.SAMPLE_WIDTH(SAMPLE_W)) out_chan ();

  fir_filter_mac #(
    .MAX_TAPS    (MAX_TAPS),
    .SAMPLE_WIDTH(SAMPLE_W),
    .COEF_WIDTH  (COEF_W)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .out_chan   (out_chan),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // Filter state as the block should hold it.
  logic signed [COEF_W-1:0]   mdl_coef [MAX_TAPS] = '{default: '0};
  logic signed [SAMPLE_W-1:0] mdl_hist [MAX_TAPS] = '{default: '0};
  logic [TAP_CNT_W-1:0]       mdl_taps = TAP_CNT_W'(1);

  fir_result_t pending_outs[$];
  fir_result_t got_res;
  fir_result_t want_res;
  int bad_results  = 0;
  int stall_cycles = 0;
  int burst_left   = 0;
  int hold_reqs    = 0;
  int holds_done   = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic void fir_model_step(input fir_item_t it);
    longint      acc;
    longint      rnd;
    int          n;
    int          i;
    fir_result_t res;
    case (it.cmd)
      CMD_LOAD_COEF: begin
        mdl_coef[it.idx] = it.coef;
      end
      CMD_CLEAR_HIST: begin
        for (i = 0; i < MAX_TAPS; i++) mdl_hist[i] = '0;
      end
      CMD_FILTER: begin
        n = (mdl_taps > MAX_TAPS) ? MAX_TAPS : int'(mdl_taps);
        acc = 0;
        for (i = 0; i < n; i++) acc += longint'(mdl_coef[i]) * longint'(mdl_hist[i]);
        // Round half up onto the sample grid, then clip.
        rnd = (acc + (64'sd1 <<< (PROD_SHIFT - 1))) >>> PROD_SHIFT;
        res.last = it.last;
        res.sat  = 1'b1;
        if (rnd > S_MAX) begin
          res.smp = S_MAX;
        end else if (rnd < S_MIN) begin
          res.smp = S_MIN;
        end else begin
          res.smp = rnd[SAMPLE_W-1:0];
          res.sat = 1'b0;
        end
        pending_outs.push_back(res);
        // The new sample enters the delay line only after the sum is formed.
        for (i = MAX_TAPS - 1; i > 0; i--) mdl_hist[i] = mdl_hist[i-1];
        mdl_hist[0] = it.smp;
      end
      default: ;
    endcase
  endfunction

  function automatic fir_item_t make_item(input logic [CMD_W-1:0] cmd,
                                          input logic [COEF_IDX_W-1:0] idx,
                                          input logic signed [COEF_W-1:0] coef,
                                          input logic signed [SAMPLE_W-1:0] smp,
                                          input logic last);
    fir_item_t it;
    it.cmd  = cmd;
    it.idx  = idx;
    it.coef = coef;
    it.smp  = smp;
    it.last = last;
    return it;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    logic signed [SAMPLE_W-1:0] s;
    case ($urandom_range(0, 7))
      0: s = S_MAX;
      1: s = S_MIN;
      2: s = SAMPLE_W'(int'($urandom_range(0, 64)) - 32);
      default: s = SAMPLE_W'($urandom);
    endcase
    return s;
  endfunction

  // Coefficients span many magnitudes so that both clipped and in-range sums occur.
  function automatic logic signed [COEF_W-1:0] rand_coef();
    logic signed [COEF_W-1:0] c;
    c = COEF_W'($urandom);
    case ($urandom_range(0, 9))
      0: c = C_MAX;
      1: c = C_MIN;
      2, 3: ;
      default: c = c >>> $urandom_range(1, 14);
    endcase
    return c;
  endfunction

  function automatic fir_item_t rand_item();
    fir_item_t it;
    int pick;
    it = make_item(CMD_FILTER, COEF_IDX_W'($urandom), rand_coef(), rand_sample(),
                   1'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      it.cmd = CMD_LOAD_COEF;
    end else if (pick < 19) begin
      it.cmd = CMD_CLEAR_HIST;
    end else if (pick < 21) begin
      it.cmd = CMD_UNUSED;
    end
    return it;
  endfunction

  // Offers one item in sender bursts and returns at the edge of its transfer.
  task automatic send_item(input fir_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 4);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
      if (gap != 0) begin
        in_chan.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_chan.valid      <= 1'b1;
    in_chan.cmd        <= it.cmd;
    in_chan.coef_index <= it.idx;
    in_chan.coef_value <= it.coef;
    in_chan.sample_in  <= it.smp;
    in_chan.last_in    <= it.last;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    fir_model_step(it);
  endtask

  // Loads and clears give no result, so a settle time follows the last result.
  task automatic drain_results();
    in_chan.valid <= 1'b0;
    while (pending_outs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_tap_count(input logic [TAP_CNT_W-1:0] n);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= n;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    mdl_taps = n;
  endtask

  task automatic test_reset_state();
    // Coefficients start at zero and one tap is in use, so all outputs are zero.
    send_item(make_item(CMD_FILTER, 0, 0, S_MAX, 1'b0));
    send_item(make_item(CMD_UNUSED, 63, C_MIN, S_MAX, 1'b1));
    send_item(make_item(CMD_FILTER, 0, 0, S_MIN, 1'b1));
    send_item(make_item(CMD_FILTER, 0, 0, 0, 1'b0));
  endtask

  task automatic test_coef_extremes();
    send_item(make_item(CMD_LOAD_COEF, 0, C_MAX, 0, 1'b0));
    send_item(make_item(CMD_FILTER, 0, 0, S_MIN, 1'b0));
    send_item(make_item(CMD_FILTER, 0, 0, S_MAX, 1'b1));
    send_item(make_item(CMD_LOAD_COEF, 0, C_MIN, 0, 1'b1));
    send_item(make_item(CMD_FILTER, 0, 0, S_MIN, 1'b0));
    send_item(make_item(CMD_FILTER, 0, 0, 0, 1'b1));
    send_item(make_item(CMD_LOAD_COEF, 0, C_NEG1, 0, 1'b0));
    send_item(make_item(CMD_FILTER, 0, 0, S_MIN, 1'b0));
    send_item(make_item(CMD_FILTER, 0, 0, 0, 1'b0));
    send_item(make_item(CMD_LOAD_COEF, 63, C_MAX, S_MIN, 1'b0));
    send_item(make_item(CMD_CLEAR_HIST, 63, C_MIN, S_MAX, 1'b1));
    send_item(make_item(CMD_FILTER, 0, 0, S_MAX, 1'b0));
  endtask

  task automatic test_tap_limits();
    drain_results();
    set_tap_count(0);
    send_item(make_item(CMD_FILTER, 0, 0, S_MAX, 1'b0));
    send_item(make_item(CMD_FILTER, 0, 0, S_MAX, 1'b1));
    drain_results();
    // Above the table size the tap count is capped.
    set_tap_count(127);
    send_item(make_item(CMD_FILTER, 0, 0, S_MIN, 1'b0));
    send_item(make_item(CMD_LOAD_COEF, 31, C_MIN, 0, 1'b0));
    send_item(make_item(CMD_FILTER, 0, 0, S_MAX, 1'b1));
    drain_results();
    set_tap_count(64);
    send_item(make_item(CMD_FILTER, 0, 0, S_MIN, 1'b0));
    send_item(make_item(CMD_FILTER, 0, 0, 0, 1'b1));
  endtask

  task automatic test_random_traffic();
    int ph;
    int k;
    int top;
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      drain_results();
      case ($urandom_range(0, 9))
        0: set_tap_count(0);
        1: set_tap_count(127);
        2: set_tap_count(64);
        3: set_tap_count(TAP_CNT_W'($urandom_range(13, 127)));
        default: set_tap_count(TAP_CNT_W'($urandom_range(1, 12)));
      endcase
      top = (mdl_taps == 0 || mdl_taps > MAX_TAPS) ? MAX_TAPS - 1 : int'(mdl_taps) - 1;
      // Fill the active taps first so that the stream that follows is meaningful.
      repeat ($urandom_range(1, 6)) begin
        send_item(make_item(CMD_LOAD_COEF, COEF_IDX_W'($urandom_range(0, top)), rand_coef(),
                            rand_sample(), 1'($urandom)));
      end
      for (k = 0; k < PHASE_ITEMS; k++) send_item(rand_item());
    end
  endtask

  task automatic test_output_stall();
    int k;
    drain_results();
    set_tap_count(3);
    hold_reqs++;
    for (k = 0; k < 30; k++) begin
      send_item(make_item(CMD_FILTER, COEF_IDX_W'($urandom), rand_coef(), rand_sample(),
                          1'($urandom)));
    end
    drain_results();
  endtask

  initial begin
    rst_n              <= 1'b0;
    cfg_wr_en          <= 1'b0;
    cfg_wr_data        <= '0;
    in_chan.valid      <= 1'b0;
    in_chan.cmd        <= '0;
    in_chan.coef_index <= '0;
    in_chan.coef_value <= '0;
    in_chan.sample_in  <= '0;
    in_chan.last_in    <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_coef_extremes();
    test_tap_limits();
    test_random_traffic();
    test_output_stall();

    drain_results();
    if (bad_results == 0 && pending_outs.size() == 0) begin
      $display("[fir_filter_mac] OK");
    end else begin
      $display("[fir_filter_mac] ERROR");
    end
    $finish;
  end

  // The result side stalls on a randomly chosen ready pattern, and on request of the stall test.
  initial begin
    logic [15:0] rx_pat;
    int rx_phase;
    out_chan.ready = 1'b0;
    rx_pat = '1;
    rx_phase = 0;
    forever begin
      @(posedge clk);
      if (holds_done != hold_reqs) begin
        holds_done++;
        out_chan.ready <= 1'b0;
        repeat (RX_HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        if (rx_phase == 0) begin
          case ($urandom_range(0, 3))
            0: rx_pat = '1;
            1: rx_pat = 16'($urandom) | 16'h1;
            2: rx_pat = 16'($urandom | $urandom);
            default: rx_pat = 16'($urandom & $urandom) | 16'h1;
          endcase
          rx_phase = 32;
        end
        rx_phase--;
        out_chan.ready <= rx_pat[rx_phase % 16];
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      got_res.smp  = out_chan.sample_out;
      got_res.last = out_chan.last_out;
      got_res.sat  = out_chan.saturated;
      if (pending_outs.size() == 0) begin
        bad_results++;
        if (bad_results <= 10) begin
          $display("unexpected result transfer: out=%0d last=%0b sat=%0b",
                   got_res.smp, got_res.last, got_res.sat);
        end
      end else begin
        want_res = pending_outs.pop_front();
        if (got_res.smp !== want_res.smp || got_res.last !== want_res.last ||
            got_res.sat !== want_res.sat) begin
          bad_results++;
          if (bad_results <= 10) begin
            $display("result mismatch: want out=%0d last=%0b sat=%0b, got out=%0d last=%0b sat=%0b",
                     want_res.smp, want_res.last, want_res.sat,
                     got_res.smp, got_res.last, got_res.sat);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("[fir_filter_mac] ERROR");
      $finish;
    end
  end

endmodule
